/* hw/rtl/jet_pkg.sv */
// Shared constants and types for the Julia escape-time block.
// No dependencies; imported by the config bank, controller, datapath and top level.
package jet_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 28;
    localparam int COUNT_WIDTH_DEF = 8;

    // squared escape radius register width is fixed
    localparam int RADIUS_WIDTH  = 31;
    localparam int CFG_IDX_WIDTH = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_C_REAL     = 2'd0,
        CFG_C_IMAG     = 2'd1,
        CFG_ITER_LIMIT = 2'd2,
        CFG_RADIUS_SQ  = 2'd3
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take a new starting point, clear the count
        logic mul;       // register the three products
        logic upd;       // step z = z*z + c, bump the count
        logic finish;    // latch the result fields
        logic escaped;   // escape flag to latch with finish
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic escape;    // |z|^2 above the bound
        logic at_limit;  // count reached the iteration limit
    } t_dp_stat;

endpackage

/* hw/rtl/julia_escape_time.sv */
// Top level of the Julia escape-time block: config bank, controller, datapath.
// Depends on jet_pkg, jet_cfg, jet_ctrl, jet_dp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  input    | start, busy            | i_z_real, i_z_imag
//  result   | o_valid (1-cycle)      | o_escape_count, o_escaped
//  config   | i_cfg_we, i_cfg_index  | i_cfg_data
//
// An item is sequenced from the accepting edge through a multiply step and then a
// compare/update step per iteration, through the shared product set, until its test
// first hits the limit or escapes; the registered result strobe then follows.
// A new item is accepted in the strobe cycle. The receiver cannot stall.
// Reset is synchronous; it restores the configuration defaults.
module julia_escape_time #(
    parameter int DataWidth  = jet_pkg::DATA_WIDTH_DEF,
    parameter int FracBits   = jet_pkg::FRAC_BITS_DEF,
    parameter int CountWidth = jet_pkg::COUNT_WIDTH_DEF,
    localparam int CfgWidth  =
        (DataWidth >= jet_pkg::RADIUS_WIDTH && DataWidth >= CountWidth) ? DataWidth :
        (jet_pkg::RADIUS_WIDTH >= CountWidth) ? jet_pkg::RADIUS_WIDTH : CountWidth
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [DataWidth-1:0]        i_z_real,
    input  logic signed [DataWidth-1:0]        i_z_imag,
    output logic                               o_valid,
    output logic [CountWidth-1:0]              o_escape_count,
    output logic                               o_escaped,
    input  logic                               i_cfg_we,
    input  logic [jet_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [CfgWidth-1:0]                i_cfg_data
);
    import jet_pkg::*;

    t_dp_cmd                 cmd;
    t_dp_stat                stat;
    logic signed [DataWidth-1:0] c_real;
    logic signed [DataWidth-1:0] c_imag;
    logic [CountWidth-1:0]   limit;
    logic [RADIUS_WIDTH-1:0] radius_sq;

    jet_cfg #(
        .DataWidth  (DataWidth),
        .FracBits   (FracBits),
        .CountWidth (CountWidth),
        .CfgWidth   (CfgWidth)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_c_real    (c_real),
        .o_c_imag    (c_imag),
        .o_limit     (limit),
        .o_radius_sq (radius_sq)
    );

    jet_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    jet_dp #(
        .DataWidth  (DataWidth),
        .FracBits   (FracBits),
        .CountWidth (CountWidth)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_z_real       (i_z_real),
        .i_z_imag       (i_z_imag),
        .i_c_real       (c_real),
        .i_c_imag       (c_imag),
        .i_limit        (limit),
        .i_radius_sq    (radius_sq),
        .o_escape_count (o_escape_count),
        .o_escaped      (o_escaped)
    );

endmodule

/* hw/rtl/jet_cfg.sv */
// Configuration register bank: Julia constant, iteration limit, squared radius.
// Depends on jet_pkg.
module jet_cfg #(
    parameter int DataWidth  = jet_pkg::DATA_WIDTH_DEF,
    parameter int FracBits   = jet_pkg::FRAC_BITS_DEF,
    parameter int CountWidth = jet_pkg::COUNT_WIDTH_DEF,
    parameter int CfgWidth   = DataWidth
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [jet_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [CfgWidth-1:0]                  i_cfg_data,
    output logic signed [DataWidth-1:0]          o_c_real,
    output logic signed [DataWidth-1:0]          o_c_imag,
    output logic [CountWidth-1:0]                o_limit,
    output logic [jet_pkg::RADIUS_WIDTH-1:0]     o_radius_sq
);
    import jet_pkg::*;

    // 0.285 and 0.01 rounded to the nearest code, 4.0 clipped to the register
    localparam longint CrRst  = ((longint'(285) << FracBits) + 500) / 1000;
    localparam longint CiRst  = ((longint'(1) << FracBits) + 50) / 100;
    localparam longint RadRst = (FracBits + 3 <= RADIUS_WIDTH) ?
                                (longint'(4) << FracBits) :
                                ((longint'(1) << RADIUS_WIDTH) - 1);

    logic signed [DataWidth-1:0]  r_c_real;
    logic signed [DataWidth-1:0]  r_c_imag;
    logic [CountWidth-1:0]        r_limit;
    logic [RADIUS_WIDTH-1:0]      r_radius_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real    <= DataWidth'(CrRst);
            r_c_imag    <= DataWidth'(CiRst);
            r_limit     <= CountWidth'(100);
            r_radius_sq <= RADIUS_WIDTH'(RadRst);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_C_REAL:     r_c_real    <= i_cfg_data[DataWidth-1:0];
                CFG_C_IMAG:     r_c_imag    <= i_cfg_data[DataWidth-1:0];
                CFG_ITER_LIMIT: r_limit     <= i_cfg_data[CountWidth-1:0];
                CFG_RADIUS_SQ:  r_radius_sq <= i_cfg_data[RADIUS_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_c_real    = r_c_real;
    assign o_c_imag    = r_c_imag;
    assign o_limit     = r_limit;
    assign o_radius_sq = r_radius_sq;

endmodule

/* hw/rtl/jet_dp.sv */
// Datapath: z registers, product registers, escape compare, update and count.
// Depends on jet_pkg.
module jet_dp #(
    parameter int DataWidth  = jet_pkg::DATA_WIDTH_DEF,
    parameter int FracBits   = jet_pkg::FRAC_BITS_DEF,
    parameter int CountWidth = jet_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  jet_pkg::t_dp_cmd                  i_cmd,
    output jet_pkg::t_dp_stat                 o_stat,
    input  logic signed [DataWidth-1:0]       i_z_real,
    input  logic signed [DataWidth-1:0]       i_z_imag,
    input  logic signed [DataWidth-1:0]       i_c_real,
    input  logic signed [DataWidth-1:0]       i_c_imag,
    input  logic [CountWidth-1:0]             i_limit,
    input  logic [jet_pkg::RADIUS_WIDTH-1:0]  i_radius_sq,
    output logic [CountWidth-1:0]             o_escape_count,
    output logic                              o_escaped
);
    import jet_pkg::*;

    localparam int ProdW = 2 * DataWidth;
    localparam int WideW = 2 * DataWidth + 2;

    localparam logic [WideW-1:0] RadCap = WideW'(longint'(4) << FracBits);
    localparam logic signed [WideW-1:0] VMax = (WideW'(1) << (DataWidth - 1)) - 1;
    localparam logic signed [WideW-1:0] VMin = -VMax - 1;

    logic signed [DataWidth-1:0] r_re;
    logic signed [DataWidth-1:0] r_im;
    logic signed [ProdW-1:0]     r_rr;
    logic signed [ProdW-1:0]     r_ii;
    logic signed [ProdW-1:0]     r_ri;
    logic [CountWidth-1:0]       r_count;
    logic [CountWidth-1:0]       r_out_count;
    logic                        r_out_esc;

    logic signed [DataWidth-1:0] n_re;
    logic signed [DataWidth-1:0] n_im;

    logic [WideW-1:0]        rad_cap;
    logic [WideW-1:0]        bound;
    logic [WideW-1:0]        mag;
    logic signed [WideW-1:0] diff;
    logic signed [WideW-1:0] dbl;
    logic signed [WideW-1:0] re_sum;
    logic signed [WideW-1:0] im_sum;

    // products of the current z, registered in the cycle before the compare/update step
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rr <= r_re * r_re;
            r_ii <= r_im * r_im;
            r_ri <= r_re * r_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re    <= i_z_real;
            r_im    <= i_z_imag;
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_re    <= n_re;
            r_im    <= n_im;
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_count <= r_count;
            r_out_esc   <= i_cmd.escaped;
        end
    end

    always_comb begin
        rad_cap = (WideW'(i_radius_sq) > RadCap) ? RadCap : WideW'(i_radius_sq);
        bound   = rad_cap << FracBits;
        // squares are never negative
        mag     = WideW'($unsigned(r_rr)) + WideW'($unsigned(r_ii));

        diff    = WideW'(r_rr) - WideW'(r_ii);
        dbl     = WideW'(r_ri) <<< 1;
        // arithmetic shift gives the floor for negative values
        re_sum  = (diff >>> FracBits) + WideW'(i_c_real);
        im_sum  = (dbl >>> FracBits) + WideW'(i_c_imag);

        if (re_sum > VMax) begin
            n_re = DataWidth'(VMax);
        end else if (re_sum < VMin) begin
            n_re = DataWidth'(VMin);
        end else begin
            n_re = DataWidth'(re_sum);
        end

        if (im_sum > VMax) begin
            n_im = DataWidth'(VMax);
        end else if (im_sum < VMin) begin
            n_im = DataWidth'(VMin);
        end else begin
            n_im = DataWidth'(im_sum);
        end

        o_stat.escape   = mag > bound;
        o_stat.at_limit = r_count == i_limit;
    end

    assign o_escape_count = r_out_count;
    assign o_escaped      = r_out_esc;

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd && !i_cmd.load |=> r_count == CountWidth'($past(r_count) + 1'b1))
        else $error("iteration count did not advance by one on update");

endmodule

/* hw/rtl/jet_ctrl.sv */
// Controller: sequences load, multiply and compare/update steps for one item.
// Depends on jet_pkg.
module jet_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output logic               o_valid,
    output jet_pkg::t_dp_cmd   o_cmd,
    input  jet_pkg::t_dp_stat  i_stat
);
    import jet_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_TEST = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                // limit is checked ahead of the escape test
                if (i_stat.at_limit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.escape) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.escaped = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_valid = o_cmd.finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy    = r_state != S_IDLE;
    assign o_valid = r_valid;

    a_strobe_after_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_TEST))
        else $error("result strobe without a finishing test step");

    a_start_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && start |=> r_state == S_MUL)
        else $error("accepted item did not enter the multiply step");

    a_no_update_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |-> !i_stat.at_limit && !i_stat.escape)
        else $error("update issued at the limit or after escape");

endmodule
